// ----- rtl/eot_pkg.sv -----
// ----------------------------------------------------------------------------
// eot_pkg: odometry tracker shared definitions
// Widths, fixed-point constants, register and word codes, helper functions.
// ----------------------------------------------------------------------------
package eot_pkg;

    localparam int COUNT_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int PW = 80;   // multiplier accumulator
    localparam int AW = 42;   // multiplicand
    localparam int BW = 36;   // multiplier magnitude
    localparam int TW = 36;   // angle, Q.30
    localparam int XW = 34;   // cordic vector, Q.30
    localparam int DW = 41;   // clamped count delta

    localparam logic [1:0] KIND_LEFT  = 2'd0;
    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] REG_MPT = 2'd0;
    localparam logic [1:0] REG_IWG = 2'd1;
    localparam logic [1:0] REG_CPM = 2'd2;
    localparam logic [1:0] REG_THR = 2'd3;

    localparam logic [23:0] MPT_RST = 24'd4096;
    localparam logic [23:0] IWG_RST = 24'd436907;
    localparam logic [23:0] CPM_RST = 24'd1310720;
    localparam logic [15:0] THR_RST = 16'd66;

    localparam logic [63:0] DELTA_MAX = 64'd549755813888;

    localparam logic signed [TW-1:0] PI30      = TW'(64'sd3373259426);
    localparam logic signed [TW-1:0] TWO_PI30  = TW'(64'sd6746518852);
    localparam logic signed [TW-1:0] HALF_PI30 = TW'(64'sd1686629713);
    localparam logic signed [XW-1:0] GAIN30    = XW'(64'sd652032874);
    localparam logic signed [20:0]   PI16      = 21'sd205887;
    localparam logic signed [20:0]   TWO_PI16  = 21'sd411775;

    localparam logic signed [PW-1:0] P_MAX32 = PW'(64'sh7FFFFFFF);
    localparam logic signed [PW-1:0] P_MIN32 = -P_MAX32 - PW'(1);
    localparam logic signed [PW-1:0] P_DTH   = PW'(524287);
    localparam logic signed [PW-1:0] P_MAXC  = PW'(32767);
    localparam logic signed [PW-1:0] P_MINC  = -P_MAXC - PW'(1);
    localparam logic signed [PW-1:0] R8      = PW'(128);
    localparam logic signed [PW-1:0] R16     = PW'(32768);
    localparam logic signed [PW-1:0] R30     = PW'(64'sd536870912);
    localparam logic signed [PW-1:0] R32     = PW'(64'sd2147483648);

    typedef struct packed {
        logic signed [PW-1:0] ma;
        logic [BW-1:0]        mb;
        logic                 neg;
    } t_mul;

    function automatic t_mul f_mul_load(logic signed [AW-1:0] a, logic signed [BW:0] b);
        t_mul m;
        m.ma  = PW'(a);
        m.mb  = b[BW] ? BW'(-b) : BW'(b);
        m.neg = b[BW];
        return m;
    endfunction

    function automatic logic signed [PW-1:0] f_sat(logic signed [PW-1:0] v,
                                                   logic signed [PW-1:0] lo,
                                                   logic signed [PW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic signed [19:0] f_wrap(logic signed [19:0] h, logic signed [19:0] d);
        logic signed [20:0] s;
        s = 21'(h) + 21'(d);
        if (s < 0) s = s + TWO_PI16;
        if (s < 0) s = s + TWO_PI16;
        if (s >= TWO_PI16) s = s - TWO_PI16;
        if (s > PI16) s = s - TWO_PI16;
        return 20'(s);
    endfunction

    function automatic logic signed [TW-1:0] f_ang2(logic signed [19:0] h, logic signed [19:0] d);
        return (TW'(h) <<< 14) + (TW'(d) <<< 13);
    endfunction

    function automatic logic signed [TW-1:0] f_atan(logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return TW'(v);
    endfunction

endpackage

// ----- rtl/encoder_odometry_tracker.sv -----
// The tick time is set by the bit-serial multiplier (one multiplier bit a cycle, ends
// once the remaining multiplier bits are zero), one or two CORDIC runs and, on a turn,
// the restoring divider. One word is in flight at a time; the result register frees
// the input while a result waits. Reset is synchronous, active low: counts, pose,
// heading and registers return to their reset values.
// ----------------------------------------------------------------------------
// encoder_odometry_tracker
// Differential-drive odometry from quadrature edges, with map cell output.
// ----------------------------------------------------------------------------
module encoder_odometry_tracker #(
    parameter int COUNT_BITS   = eot_pkg::COUNT_BITS_DEF,
    parameter int CORDIC_STEPS = eot_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic               i_phase_a,
    input  logic               i_phase_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_x_cell,
    output logic signed [15:0] o_y_cell,
    output logic signed [18:0] o_heading,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import eot_pkg::*;

    localparam int CIW = $clog2(CORDIC_STEPS);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_ML   = 15'b000000000000010,
        S_MR   = 15'b000000000000100,
        S_MD   = 15'b000000000001000,
        S_RED  = 15'b000000000010000,
        S_FOLD = 15'b000000000100000,
        S_ITER = 15'b000000001000000,
        S_CX   = 15'b000000010000000,
        S_CY   = 15'b000000100000000,
        S_MS   = 15'b000001000000000,
        S_DIV  = 15'b000010000000000,
        S_MX   = 15'b000100000000000,
        S_MY   = 15'b001000000000000,
        S_CLX  = 15'b010000000000000,
        S_CLY  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_lc, n_lc, r_rc, n_rc, r_lp, n_lp, r_rp, n_rp;
    logic [23:0] r_mpt, n_mpt, r_iwg, n_iwg, r_cpm, n_cpm;
    logic [15:0] r_thr, n_thr;
    logic signed [31:0] r_x_metres, n_x_metres, r_y_metres, n_y_metres;
    logic signed [19:0] r_heading, n_heading;
    logic r_ov, n_ov, r_rot2, n_rot2;
    logic [CIW-1:0] r_ci, n_ci;
    logic [5:0] r_dcnt, n_dcnt;

    logic signed [DW-1:0] r_dr, n_dr;
    logic signed [31:0] r_lm, n_lm, r_rm, n_rm;
    logic signed [19:0] r_dth, n_dth;
    logic [18:0] r_adth, n_adth;
    logic [32:0] r_asum, n_asum;
    logic [30:0] r_travel, n_travel;
    logic signed [TW-1:0] r_rt, n_rt;
    logic signed [XW-1:0] r_rx, n_rx, r_ry, n_ry, r_xn, n_xn, r_s, n_s;
    logic r_flip, n_flip;
    logic [63:0] r_dd, n_dd, r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic signed [PW-1:0] r_ma, n_ma, r_acc, n_acc;
    logic [BW-1:0] r_mb, n_mb;
    logic r_neg, n_neg;
    logic signed [15:0] r_xcell, n_xcell, r_ox, n_ox, r_oy, n_oy;
    logic signed [18:0] r_oh, n_oh;

    logic signed [PW-1:0] c_prod;
    logic c_mdone, c_same, c_wr;
    logic signed [XW-1:0] c_dx, c_dy, c_xi, c_yi, c_yn, c_cv;
    logic [XW-1:0] c_sabs;
    logic signed [TW-1:0] c_atan, c_ti, c_tw;
    logic signed [31:0] c_m8;
    logic signed [32:0] c_diff, c_sum;
    logic signed [19:0] c_dth;
    logic [18:0] c_adth;
    logic [32:0] c_asum;
    logic [33:0] c_half;
    logic [32:0] c_den;
    logic [33:0] c_rr;
    logic c_ge;
    logic [63:0] c_qn;
    t_mul c_ml;

    function automatic logic signed [DW-1:0] f_delta(logic [COUNT_BITS-1:0] now,
                                                     logic [COUNT_BITS-1:0] prev);
        logic [COUNT_BITS-1:0] d;
        logic [COUNT_BITS-1:0] mag;
        logic [63:0] m64;
        d   = now - prev;
        mag = d[COUNT_BITS-1] ? -d : d;
        m64 = 64'(mag);
        if (m64 > DELTA_MAX) m64 = DELTA_MAX;
        return d[COUNT_BITS-1] ? -$signed(DW'(m64)) : $signed(DW'(m64));
    endfunction

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_ov;
    assign o_x_cell  = r_ox;
    assign o_y_cell  = r_oy;
    assign o_heading = r_oh;
    assign pready    = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_MPT: prdata = {8'd0, r_mpt};
            REG_IWG: prdata = {8'd0, r_iwg};
            REG_CPM: prdata = {8'd0, r_cpm};
            REG_THR: prdata = {16'd0, r_thr};
            default: prdata = '0;
        endcase
    end

    assign c_prod  = r_neg ? -r_acc : r_acc;
    assign c_mdone = (r_mb == '0);
    assign c_same  = (i_phase_a == i_phase_b);
    assign c_wr    = psel && penable && pwrite;

    // cordic step
    assign c_dx   = r_ry >>> r_ci;
    assign c_dy   = r_rx >>> r_ci;
    assign c_atan = f_atan(5'(r_ci));
    assign c_xi   = r_rt[TW-1] ? r_rx + c_dx : r_rx - c_dx;
    assign c_yi   = r_rt[TW-1] ? r_ry - c_dy : r_ry + c_dy;
    assign c_ti   = r_rt[TW-1] ? r_rt + c_atan : r_rt - c_atan;
    assign c_tw   = (r_rt > PI30) ? r_rt - TWO_PI30 : r_rt;
    assign c_yn   = r_ry + XW'(c_prod >>> 30);
    assign c_cv   = r_flip ? -r_xn : r_xn;
    assign c_sabs = c_yn[XW-1] ? XW'(-c_yn) : XW'(c_yn);

    assign c_m8   = 32'(f_sat((c_prod + R8) >>> 8, P_MIN32, P_MAX32));
    assign c_diff = 33'(r_lm) - 33'(c_m8);
    assign c_dth  = 20'(f_sat((c_prod + R16) >>> 16, -P_DTH, P_DTH));
    assign c_adth = c_dth[19] ? 19'(-c_dth) : 19'(c_dth);
    assign c_sum  = 33'(r_lm) + 33'(r_rm);
    assign c_asum = c_sum[32] ? 33'(-c_sum) : 33'(c_sum);
    assign c_half = (34'(c_asum) + 34'd1) >> 1;

    // restoring divider, one quotient bit a cycle
    assign c_den = {r_adth, 14'd0};
    assign c_rr  = {r_rem, r_dd[63]};
    assign c_ge  = (c_rr >= 34'(c_den));
    assign c_qn  = {r_q[62:0], c_ge};

    always_comb begin
        n_state = r_state;
        n_lc = r_lc;  n_rc = r_rc;  n_lp = r_lp;  n_rp = r_rp;
        n_mpt = r_mpt;  n_iwg = r_iwg;  n_cpm = r_cpm;  n_thr = r_thr;
        n_x_metres = r_x_metres;  n_y_metres = r_y_metres;  n_heading = r_heading;
        n_ov = r_ov && !i_ready;
        n_rot2 = r_rot2;  n_ci = r_ci;  n_dcnt = r_dcnt;
        n_dr = r_dr;  n_lm = r_lm;  n_rm = r_rm;  n_dth = r_dth;  n_adth = r_adth;
        n_asum = r_asum;  n_travel = r_travel;
        n_rt = r_rt;  n_rx = r_rx;  n_ry = r_ry;  n_xn = r_xn;  n_s = r_s;
        n_flip = r_flip;
        n_dd = r_dd;  n_q = r_q;  n_rem = r_rem;
        n_xcell = r_xcell;  n_ox = r_ox;  n_oy = r_oy;  n_oh = r_oh;
        n_neg = r_neg;
        c_ml = '0;
        if (r_mb != '0) begin
            n_acc = r_mb[0] ? r_acc + r_ma : r_acc;
            n_ma  = r_ma <<< 1;
            n_mb  = r_mb >> 1;
        end else begin
            n_acc = r_acc;
            n_ma  = r_ma;
            n_mb  = r_mb;
        end

        if (c_wr) begin
            unique case (paddr[3:2])
                REG_MPT: n_mpt = pwdata[23:0];
                REG_IWG: n_iwg = pwdata[23:0];
                REG_CPM: n_cpm = pwdata[23:0];
                REG_THR: n_thr = pwdata[15:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_kind)
                        KIND_LEFT:  n_lc = c_same ? r_lc - 1'b1 : r_lc + 1'b1;
                        KIND_RIGHT: n_rc = c_same ? r_rc - 1'b1 : r_rc + 1'b1;
                        KIND_TICK: begin
                            n_lp = r_lc;
                            n_rp = r_rc;
                            n_dr = f_delta(r_rc, r_rp);
                            c_ml = f_mul_load(AW'(f_delta(r_lc, r_lp)), (BW+1)'(r_mpt));
                            n_state = S_ML;
                        end
                        KIND_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_ML: if (c_mdone) begin
                n_lm = c_m8;
                c_ml = f_mul_load(AW'(r_dr), (BW+1)'(r_mpt));
                n_state = S_MR;
            end
            S_MR: if (c_mdone) begin
                n_rm = c_m8;
                c_ml = f_mul_load(AW'(c_diff), (BW+1)'(r_iwg));
                n_state = S_MD;
            end
            S_MD: if (c_mdone) begin
                n_dth  = c_dth;
                n_adth = c_adth;
                n_asum = c_asum;
                if (c_adth > 19'(r_thr)) begin
                    n_rt   = TW'(c_dth) <<< 13;
                    n_rot2 = 1'b0;
                end else begin
                    n_travel = c_half[33:31] != '0 ? 31'h7FFFFFFF : c_half[30:0];
                    n_rt     = f_ang2(r_heading, c_dth);
                    n_rot2   = 1'b1;
                end
                n_state = S_RED;
            end
            S_RED: begin
                if (r_rt[TW-1]) n_rt = r_rt + TWO_PI30;
                else if (r_rt >= TWO_PI30) n_rt = r_rt - TWO_PI30;
                else n_state = S_FOLD;
            end
            S_FOLD: begin
                n_flip = 1'b0;
                n_rt   = c_tw;
                if (c_tw > HALF_PI30) begin
                    n_rt = PI30 - c_tw;  n_flip = 1'b1;
                end else if (c_tw < -HALF_PI30) begin
                    n_rt = -PI30 - c_tw;  n_flip = 1'b1;
                end
                n_rx = GAIN30;
                n_ry = '0;
                n_ci = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                n_rx = c_xi;
                n_ry = c_yi;
                n_rt = c_ti;
                n_ci = r_ci + 1'b1;
                if (r_ci == CIW'(CORDIC_STEPS - 1)) begin
                    c_ml = f_mul_load(AW'(c_yi), (BW+1)'(c_ti));
                    n_state = S_CX;
                end
            end
            S_CX: if (c_mdone) begin
                n_xn = r_rx - XW'(c_prod >>> 30);
                c_ml = f_mul_load(AW'(r_rx), (BW+1)'(r_rt));
                n_state = S_CY;
            end
            S_CY: if (c_mdone) begin
                if (!r_rot2) begin
                    c_ml = f_mul_load(AW'({1'b0, r_asum}), (BW+1)'(c_sabs));
                    n_state = S_MS;
                end else begin
                    n_s = c_yn;
                    c_ml = f_mul_load(AW'(c_cv), (BW+1)'(r_travel));
                    n_state = S_MX;
                end
            end
            S_MS: if (c_mdone) begin
                n_dd   = 64'(c_prod) + 64'({r_adth, 13'd0});
                n_rem  = '0;
                n_q    = '0;
                n_dcnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = c_ge ? 33'(c_rr - 34'(c_den)) : 33'(c_rr);
                n_dd   = r_dd << 1;
                n_q    = c_qn;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 6'd63) begin
                    n_travel = (c_qn[63:31] != '0) ? 31'h7FFFFFFF : c_qn[30:0];
                    n_rt     = f_ang2(r_heading, r_dth);
                    n_rot2   = 1'b1;
                    n_state  = S_RED;
                end
            end
            S_MX: if (c_mdone) begin
                n_x_metres = 32'(f_sat(PW'(r_x_metres) + ((c_prod + R30) >>> 30),
                                       P_MIN32, P_MAX32));
                c_ml = f_mul_load(AW'(r_s), (BW+1)'(r_travel));
                n_state = S_MY;
            end
            S_MY: if (c_mdone) begin
                n_y_metres = 32'(f_sat(PW'(r_y_metres) + ((c_prod + R30) >>> 30),
                                       P_MIN32, P_MAX32));
                n_heading = f_wrap(r_heading, r_dth);
                c_ml = f_mul_load(AW'(r_x_metres), (BW+1)'(r_cpm));
                n_state = S_CLX;
            end
            S_CLX: if (c_mdone) begin
                n_xcell = 16'(f_sat((c_prod + R32) >>> 32, P_MINC, P_MAXC));
                c_ml = f_mul_load(AW'(r_y_metres), (BW+1)'(r_cpm));
                n_state = S_CLY;
            end
            S_CLY: if (c_mdone && (!r_ov || i_ready)) begin
                n_ox = r_xcell;
                n_oy = 16'(f_sat((c_prod + R32) >>> 32, P_MINC, P_MAXC));
                n_oh = 19'(r_heading);
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (n_state != r_state && c_ml.mb != '0 || (n_state != r_state &&
            (n_state == S_ML || n_state == S_MR || n_state == S_MD || n_state == S_CX ||
             n_state == S_CY || n_state == S_MS || n_state == S_MX || n_state == S_MY ||
             n_state == S_CLX || n_state == S_CLY))) begin
            n_ma  = c_ml.ma;
            n_mb  = c_ml.mb;
            n_neg = c_ml.neg;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lc       <= '0;
            r_rc       <= '0;
            r_lp       <= '0;
            r_rp       <= '0;
            r_mpt      <= MPT_RST;
            r_iwg      <= IWG_RST;
            r_cpm      <= CPM_RST;
            r_thr      <= THR_RST;
            r_x_metres <= '0;
            r_y_metres <= '0;
            r_heading  <= '0;
            r_ov       <= 1'b0;
            r_rot2     <= 1'b0;
            r_ci       <= '0;
            r_dcnt     <= '0;
            r_mb       <= '0;
        end else begin
            r_state    <= n_state;
            r_lc       <= n_lc;
            r_rc       <= n_rc;
            r_lp       <= n_lp;
            r_rp       <= n_rp;
            r_mpt      <= n_mpt;
            r_iwg      <= n_iwg;
            r_cpm      <= n_cpm;
            r_thr      <= n_thr;
            r_x_metres <= n_x_metres;
            r_y_metres <= n_y_metres;
            r_heading  <= n_heading;
            r_ov       <= n_ov;
            r_rot2     <= n_rot2;
            r_ci       <= n_ci;
            r_dcnt     <= n_dcnt;
            r_mb       <= n_mb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dr     <= n_dr;
        r_lm     <= n_lm;
        r_rm     <= n_rm;
        r_dth    <= n_dth;
        r_adth   <= n_adth;
        r_asum   <= n_asum;
        r_travel <= n_travel;
        r_rt     <= n_rt;
        r_rx     <= n_rx;
        r_ry     <= n_ry;
        r_xn     <= n_xn;
        r_s      <= n_s;
        r_flip   <= n_flip;
        r_dd     <= n_dd;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_ma     <= n_ma;
        r_acc    <= n_acc;
        r_neg    <= n_neg;
        r_xcell  <= n_xcell;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_oh     <= n_oh;
    end

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind == KIND_TICK) |=> !o_ready)
        else $error("tick word did not start the update sequence");

    a_edge_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_kind != KIND_TICK) |=> $stable(r_x_metres) && $stable(r_y_metres))
        else $error("edge word moved the pose");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_adth != '0))
        else $error("chord divide by zero heading change");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading >= -19'sd205887 && o_heading <= 19'sd205887))
        else $error("heading out of range");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_CLY))
        else $error("result word raised outside the final step");

endmodule
